### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks of the polar-to-Cartesian block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge, off during reset
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on the rising edge, off during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/lspc_pkg.sv
// ----------------------------------------------------------------------------
// lspc_pkg
// Widths, constants, command types and the CORDIC arctangent table shared by
// the laser scan polar-to-Cartesian modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lspc_pkg;

  // Field widths
  localparam int RANGE_W    = 16;
  localparam int ANGLE_W    = 16;
  localparam int OUT_W      = 17;
  localparam int PCOUNT_W   = 12;
  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = 40;

  // Scan bookkeeping
  localparam int MAX_POINTS = 2048;
  localparam int IDX_W      = $clog2(MAX_POINTS);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = 16;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 2'd2;
  localparam logic [PCOUNT_W-1:0]  POINT_COUNT_RST = 12'd1081;

  // CORDIC
  localparam int CORDIC_ITERATIONS = 16;
  localparam int ITER_W     = $clog2(CORDIC_ITERATIONS);
  localparam int ATAN_IDX_W = 5;
  localparam int GAIN_W     = 30;
  localparam int PROD_W     = RANGE_W + GAIN_W;
  localparam int DW         = 49;              // vector components, Q30 mm
  localparam int Z_W        = 34;              // residual angle, 2^32 per turn
  localparam int FRAC_W     = 30;
  localparam int RND_W      = DW + 1 - FRAC_W; // rounded component width
  localparam logic [GAIN_W-1:0] GAIN_K =
    GAIN_W'(longint'(652032874) + (longint'(434688583) >> (2 * CORDIC_ITERATIONS)));
  localparam int OUT_LIMIT  = 65535;

  // Quarter-turn limits for the half-turn fold
  localparam logic [ANGLE_W-1:0] QUARTER_POS = 16'h4000;
  localparam logic [ANGLE_W-1:0] QUARTER_NEG = 16'hC000;
  localparam logic [ANGLE_W-1:0] HALF_TURN   = 16'h8000;

  // Controller to datapath commands
  typedef struct packed {
    logic              load;   // capture accepted item
    logic              mul;    // gain-compensated range into x
    logic              iter;   // one CORDIC micro-rotation
    logic              flip;   // undo half-turn fold
    logic              fin;    // round, saturate, write output register
    logic [ITER_W-1:0] step;   // micro-rotation index
  } cmd_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_lookup(input logic [ATAN_IDX_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### src/lspc_scan.sv
// ----------------------------------------------------------------------------
// lspc_scan
// Configuration registers and scan sequencing: beam angle and point index of
// the next sample, angle and last-of-scan flag for the item being accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module lspc_scan (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_wr_en,
  input  wire logic [lspc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lspc_pkg::CFG_W-1:0]       cfg_wdata,
  input  wire logic                             start_of_scan,
  input  wire logic                             advance,
  output logic      [lspc_pkg::ANGLE_W-1:0]     angle,
  output logic                                  last_of_scan
);

  logic [lspc_pkg::ANGLE_W-1:0]  angle_start;
  logic [lspc_pkg::ANGLE_W-1:0]  angle_step;
  logic [lspc_pkg::PCOUNT_W-1:0] point_count;
  logic [lspc_pkg::ANGLE_W-1:0]  beam_angle;
  logic [lspc_pkg::IDX_W-1:0]    point_index;

  logic [lspc_pkg::PCOUNT_W-1:0] n_eff;
  logic [lspc_pkg::IDX_W-1:0]    cur_index;

  // Effective point count: zero reads as one, large counts clamp
  always_comb begin
    if (point_count == '0) begin
      n_eff = lspc_pkg::PCOUNT_W'(1);
    end else if (point_count > lspc_pkg::PCOUNT_W'(lspc_pkg::MAX_POINTS)) begin
      n_eff = lspc_pkg::PCOUNT_W'(lspc_pkg::MAX_POINTS);
    end else begin
      n_eff = point_count;
    end
  end

  // Start-of-scan restarts from the start angle
  always_comb begin
    angle     = start_of_scan ? angle_start : beam_angle;
    cur_index = start_of_scan ? '0 : point_index;
    last_of_scan = (lspc_pkg::PCOUNT_W'(cur_index) + lspc_pkg::PCOUNT_W'(1)) >= n_eff;
  end

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_start <= '0;
      angle_step  <= '0;
      point_count <= lspc_pkg::POINT_COUNT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        lspc_pkg::REG_ANGLE_START: angle_start <= cfg_wdata;
        lspc_pkg::REG_ANGLE_STEP:  angle_step  <= cfg_wdata;
        lspc_pkg::REG_POINT_COUNT: point_count <= cfg_wdata[lspc_pkg::PCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Beam angle and index advance once per accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      beam_angle  <= '0;
      point_index <= '0;
    end else if (advance) begin
      if (last_of_scan) begin
        beam_angle  <= angle_start;
        point_index <= '0;
      end else begin
        beam_angle  <= angle + angle_step;
        point_index <= cur_index + lspc_pkg::IDX_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

### src/lspc_ctrl.sv
// ----------------------------------------------------------------------------
// lspc_ctrl
// Controller: sequences capture, gain multiply, CORDIC micro-rotations,
// sign fold and output write for one item at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module lspc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic            out_free,
  output logic                 in_ready,
  output lspc_pkg::cmd_t       cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ITER,
    ST_FLIP,
    ST_DONE
  } state_t;

  state_t                    state;
  logic [lspc_pkg::ITER_W-1:0] iter_cnt;

  // Command decode
  always_comb begin
    in_ready = (state == ST_IDLE);
    cmd.load = (state == ST_IDLE) && in_valid;
    cmd.mul  = (state == ST_MUL);
    cmd.iter = (state == ST_ITER);
    cmd.flip = (state == ST_FLIP);
    cmd.fin  = (state == ST_DONE) && out_free;
    cmd.step = iter_cnt;
  end

  // State and iteration count
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      iter_cnt <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) state <= ST_MUL;
        end
        ST_MUL: begin
          iter_cnt <= '0;
          state    <= ST_ITER;
        end
        ST_ITER: begin
          if (iter_cnt == lspc_pkg::ITER_W'(lspc_pkg::CORDIC_ITERATIONS - 1)) begin
            state <= ST_FLIP;
          end else begin
            iter_cnt <= iter_cnt + lspc_pkg::ITER_W'(1);
          end
        end
        ST_FLIP: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### src/lspc_datapath.sv
// ----------------------------------------------------------------------------
// lspc_datapath
// Iterative rotation-mode CORDIC: gain-compensated range load, one
// micro-rotation per cycle, half-turn fold undo, rounding, saturation and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lspc_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire lspc_pkg::cmd_t                cmd,
  input  wire logic [lspc_pkg::RANGE_W-1:0]  range_mm,
  input  wire logic [lspc_pkg::ANGLE_W-1:0]  angle,
  input  wire logic                          last_in,
  input  wire logic                          out_ready,
  output logic                               out_free,
  output logic                               out_valid,
  output logic      [lspc_pkg::OUT_W-1:0]    x_mm,
  output logic      [lspc_pkg::OUT_W-1:0]    y_mm,
  output logic                               last_of_scan
);

  logic [lspc_pkg::RANGE_W-1:0]   r_q;
  logic [lspc_pkg::ANGLE_W-1:0]   angle_q;
  logic                           last_q;
  logic                           flip_q;
  logic signed [lspc_pkg::DW-1:0]  x;
  logic signed [lspc_pkg::DW-1:0]  y;
  logic signed [lspc_pkg::Z_W-1:0] z;

  logic                           flip_c;
  logic [lspc_pkg::ANGLE_W-1:0]   angle_f;
  logic [lspc_pkg::PROD_W-1:0]    prod;
  logic signed [lspc_pkg::DW-1:0]  dx;
  logic signed [lspc_pkg::DW-1:0]  dy;
  logic signed [lspc_pkg::Z_W-1:0] at;
  logic signed [lspc_pkg::OUT_W-1:0] cos_mm;
  logic signed [lspc_pkg::OUT_W-1:0] sin_mm;

  // Round to whole millimetres (floor after adding one half), then saturate
  function automatic logic signed [lspc_pkg::OUT_W-1:0] round_sat(
    input logic signed [lspc_pkg::DW-1:0] v
  );
    logic signed [lspc_pkg::DW:0]      sum;
    logic signed [lspc_pkg::RND_W-1:0] r;
    logic signed [lspc_pkg::OUT_W-1:0] res;
    sum = {v[lspc_pkg::DW-1], v} + ((lspc_pkg::DW+1)'(1) <<< (lspc_pkg::FRAC_W - 1));
    r   = sum[lspc_pkg::DW:lspc_pkg::FRAC_W];
    if (r > lspc_pkg::RND_W'(lspc_pkg::OUT_LIMIT)) begin
      res = lspc_pkg::OUT_W'(lspc_pkg::OUT_LIMIT);
    end else if (r < -lspc_pkg::RND_W'(lspc_pkg::OUT_LIMIT)) begin
      res = -lspc_pkg::OUT_W'(lspc_pkg::OUT_LIMIT);
    end else begin
      res = r[lspc_pkg::OUT_W-1:0];
    end
    return res;
  endfunction

  // Angles past a quarter turn fold by a half turn
  always_comb begin
    flip_c  = (angle_q > lspc_pkg::QUARTER_POS) && (angle_q < lspc_pkg::QUARTER_NEG);
    angle_f = flip_c ? (angle_q ^ lspc_pkg::HALF_TURN) : angle_q;
    prod    = lspc_pkg::PROD_W'(r_q) * lspc_pkg::PROD_W'(lspc_pkg::GAIN_K);
  end

  // Micro-rotation terms
  always_comb begin
    dx = y >>> cmd.step;
    dy = x >>> cmd.step;
    at = signed'(lspc_pkg::Z_W'(lspc_pkg::atan_lookup(lspc_pkg::ATAN_IDX_W'(cmd.step))));
  end

  always_comb begin
    cos_mm = round_sat(x);
    sin_mm = round_sat(y);
  end

  // Item capture and CORDIC registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_q     <= range_mm;
      angle_q <= angle;
      last_q  <= last_in;
    end
    if (cmd.mul) begin
      x      <= signed'(lspc_pkg::DW'(prod));
      y      <= '0;
      z      <= signed'({{(lspc_pkg::Z_W-32){angle_f[lspc_pkg::ANGLE_W-1]}},
                         angle_f, 16'h0000});
      flip_q <= flip_c;
    end
    if (cmd.iter) begin
      if (!z[lspc_pkg::Z_W-1]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - at;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + at;
      end
    end
    if (cmd.flip && flip_q) begin
      x <= -x;
      y <= -y;
    end
  end

  // Output register
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      x_mm         <= -sin_mm;
      y_mm         <= cos_mm;
      last_of_scan <= last_q;
    end
  end

endmodule

`default_nettype wire

### src/laser_scan_polar_to_cartesian.sv
// ----------------------------------------------------------------------------
// laser_scan_polar_to_cartesian
// Converts laser range samples to Cartesian points, x = -r*sin(a) and
// y = r*cos(a), with the beam angle stepped per sample over a scan.
// ----------------------------------------------------------------------------
//  Channel   Dir  Fields (low bit first)
//  s_*       in   tdata: range_mm[15:0]; tuser: start_of_scan
//  m_*       out  tdata: x_mm[16:0], y_mm[33:17], zero pad; tlast: last_of_scan
//  cfg_*     in   index 0 angle_start, 1 angle_step, 2 point_count
//
//  Each item runs from acceptance to the next acceptance through capture,
//  one gain multiply, 16 CORDIC micro-rotations on a single shared stage, the
//  sign fold and the output write; the next item waits for this one's write.
//  Reset is synchronous; the result register lets a new item start while the
//  previous result is still held; only a full result register stalls the loop.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module laser_scan_polar_to_cartesian (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // range_mm[15:0]
  input  wire logic [lspc_pkg::S_TDATA_W-1:0]    s_tdata,
  // start_of_scan[0]
  input  wire logic [0:0]                        s_tuser,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // x_mm[16:0], y_mm[33:17], zeros[39:34]
  output logic      [lspc_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic                                   m_tlast,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  input  wire logic                              cfg_wr_en,
  input  wire logic [lspc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lspc_pkg::CFG_W-1:0]        cfg_wdata
);

  lspc_pkg::cmd_t                 cmd;
  logic                           out_free;
  logic [lspc_pkg::ANGLE_W-1:0]   cur_angle;
  logic                           cur_last;
  logic [lspc_pkg::OUT_W-1:0]     x_mm;
  logic [lspc_pkg::OUT_W-1:0]     y_mm;

  // Scan sequencing and configuration
  lspc_scan u_scan (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .start_of_scan(s_tuser[0]),
    .advance      (cmd.load),
    .angle        (cur_angle),
    .last_of_scan (cur_last)
  );

  // Controller
  lspc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .out_free(out_free),
    .in_ready(s_tready),
    .cmd     (cmd)
  );

  // CORDIC datapath and output register
  lspc_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .range_mm    (s_tdata[lspc_pkg::RANGE_W-1:0]),
    .angle       (cur_angle),
    .last_in     (cur_last),
    .out_ready   (m_tready),
    .out_free    (out_free),
    .out_valid   (m_tvalid),
    .x_mm        (x_mm),
    .y_mm        (y_mm),
    .last_of_scan(m_tlast)
  );

  assign m_tdata = {{(lspc_pkg::M_TDATA_W - 2*lspc_pkg::OUT_W){1'b0}}, y_mm, x_mm};

  // Checks
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready, "accepted while busy")
  `ASSERT_IMPL(a_out_in_range, clk, rst, m_tvalid, (m_tdata[16:0] != 17'h10000) && (m_tdata[33:17] != 17'h10000), "result outside saturation range")
  `ASSERT_IMPL(a_result_after_work, clk, rst, $rose(m_tvalid), !$past(s_tready), "result without work in flight")

endmodule

`default_nettype wire
